// ===== sv/tie_pkg.sv =====
package tie_pkg;

   localparam int CELLS_PER_DIM_DEF = 2;
   localparam int NUM_FUNCS_DEF     = 4;
   localparam int AXES              = 4;
   localparam int NMONO             = 256;
   localparam int MONO_W            = 8;
   localparam int STORE_DEPTH       = 16384;
   localparam int ADDR_W            = 14;
   localparam int COEF_W            = 32;
   localparam int COORD_W           = 32;
   localparam int INV_W             = 31;
   localparam int VALUE_W           = 40;
   localparam int FUNC_W            = 3;
   localparam int FIDX_OUT_W        = 2;
   localparam int CELL_W            = 3;
   localparam int CELLNO_W          = 4 * CELL_W;
   localparam int FRAC_W            = 16;
   localparam int PW_W              = 17;
   localparam int ACC_W             = 58;
   localparam int Q_DEPTH           = 2;
   localparam int CSR_ADDR_W        = 5;
   localparam int CSR_DATA_W        = 32;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   localparam logic [2:0] REG_ORIGIN_1   = 3'd0;
   localparam logic [2:0] REG_ORIGIN_2   = 3'd1;
   localparam logic [2:0] REG_ORIGIN_3   = 3'd2;
   localparam logic [2:0] REG_ORIGIN_4   = 3'd3;
   localparam logic [2:0] REG_INV_STEP_1 = 3'd4;
   localparam logic [2:0] REG_INV_STEP_2 = 3'd5;
   localparam logic [2:0] REG_INV_STEP_3 = 3'd6;
   localparam logic [2:0] REG_INV_STEP_4 = 3'd7;

   localparam logic [INV_W-1:0] INV_STEP_RESET = 31'd65536;

   typedef struct packed {
      logic                           command;
      logic [ADDR_W-1:0]              coef_address;
      logic [COEF_W-1:0]              coef_value;
      logic [AXES-1:0][COORD_W-1:0]   coord;
   } entry_type;

   typedef struct packed {
      logic [AXES-1:0][COORD_W-1:0]   origin;
      logic [AXES-1:0][INV_W-1:0]     inv_step;
   } cfg_type;

endpackage

// ===== sv/tetracubic_interpolation_evaluator.sv =====
// channel  | direction | ports                          | moves
// req      | in        | req_valid/req_ready + fields   | one load or evaluate word
// rsp      | out       | rsp_valid/rsp_ready + fields   | one result word per function
// csr      | in/out    | csr_psel..csr_pready           | 32-bit register access
//
// Load: written to the coefficient memory from IDLE. Evaluate: accepted in IDLE, then
// DIFF, MUL, CLS, P2 and P3 per axis locate the cell and build powers; per function,
// RUN does 256 MACs on the single coefficient memory read port, then DRAIN and EMIT.
// Reset is synchronous; the coefficient memory is not cleared.
// A two-word queue lets req accept while the back end works; rsp stalls hold
// the back end at the end of each function.
module tetracubic_interpolation_evaluator #(
   parameter int CELLS_PER_DIM = tie_pkg::CELLS_PER_DIM_DEF,
   parameter int NUM_FUNCS     = tie_pkg::NUM_FUNCS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_command,
   input  logic [tie_pkg::ADDR_W-1:0]            req_coef_address,
   input  logic signed [tie_pkg::COEF_W-1:0]     req_coef_value,
   input  logic signed [tie_pkg::COORD_W-1:0]    req_coord_1,
   input  logic signed [tie_pkg::COORD_W-1:0]    req_coord_2,
   input  logic signed [tie_pkg::COORD_W-1:0]    req_coord_3,
   input  logic signed [tie_pkg::COORD_W-1:0]    req_coord_4,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [tie_pkg::FIDX_OUT_W-1:0]        rsp_func_index,
   output logic signed [tie_pkg::VALUE_W-1:0]    rsp_value,
   output logic                                  rsp_out_of_range,
   output logic                                  rsp_last,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [tie_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [tie_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [tie_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);

   localparam logic [tie_pkg::FIDX_OUT_W-1:0] LAST_IDX = tie_pkg::FIDX_OUT_W'(NUM_FUNCS - 1);

   tie_pkg::cfg_type cfg_ff, cfg_in;
   tie_pkg::entry_type q_entry;
   logic q_valid, q_ready, csr_we;
   logic [2:0] csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_we     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_idx)
            tie_pkg::REG_ORIGIN_1:   cfg_in.origin[0]   = csr_pwdata;
            tie_pkg::REG_ORIGIN_2:   cfg_in.origin[1]   = csr_pwdata;
            tie_pkg::REG_ORIGIN_3:   cfg_in.origin[2]   = csr_pwdata;
            tie_pkg::REG_ORIGIN_4:   cfg_in.origin[3]   = csr_pwdata;
            tie_pkg::REG_INV_STEP_1: cfg_in.inv_step[0] = csr_pwdata[tie_pkg::INV_W-1:0];
            tie_pkg::REG_INV_STEP_2: cfg_in.inv_step[1] = csr_pwdata[tie_pkg::INV_W-1:0];
            tie_pkg::REG_INV_STEP_3: cfg_in.inv_step[2] = csr_pwdata[tie_pkg::INV_W-1:0];
            tie_pkg::REG_INV_STEP_4: cfg_in.inv_step[3] = csr_pwdata[tie_pkg::INV_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         tie_pkg::REG_ORIGIN_1:   csr_prdata = cfg_ff.origin[0];
         tie_pkg::REG_ORIGIN_2:   csr_prdata = cfg_ff.origin[1];
         tie_pkg::REG_ORIGIN_3:   csr_prdata = cfg_ff.origin[2];
         tie_pkg::REG_ORIGIN_4:   csr_prdata = cfg_ff.origin[3];
         tie_pkg::REG_INV_STEP_1: csr_prdata = {1'b0, cfg_ff.inv_step[0]};
         tie_pkg::REG_INV_STEP_2: csr_prdata = {1'b0, cfg_ff.inv_step[1]};
         tie_pkg::REG_INV_STEP_3: csr_prdata = {1'b0, cfg_ff.inv_step[2]};
         tie_pkg::REG_INV_STEP_4: csr_prdata = {1'b0, cfg_ff.inv_step[3]};
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin      <= '0;
         cfg_ff.inv_step[0] <= tie_pkg::INV_STEP_RESET;
         cfg_ff.inv_step[1] <= tie_pkg::INV_STEP_RESET;
         cfg_ff.inv_step[2] <= tie_pkg::INV_STEP_RESET;
         cfg_ff.inv_step[3] <= tie_pkg::INV_STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tie_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_coef_address (req_coef_address),
      .req_coef_value   (req_coef_value),
      .req_coord_1      (req_coord_1),
      .req_coord_2      (req_coord_2),
      .req_coord_3      (req_coord_3),
      .req_coord_4      (req_coord_4),
      .q_valid          (q_valid),
      .q_ready          (q_ready),
      .q_entry          (q_entry)
   );

   tie_back #(
      .CELLS_PER_DIM (CELLS_PER_DIM),
      .NUM_FUNCS     (NUM_FUNCS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_valid          (q_valid),
      .q_ready          (q_ready),
      .q_entry          (q_entry),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_func_index   (rsp_func_index),
      .rsp_value        (rsp_value),
      .rsp_out_of_range (rsp_out_of_range),
      .rsp_last         (rsp_last)
   );

   last_flag_matches_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_func_index == LAST_IDX)))
      else $error("rsp_last does not match final function index");

   eval_blocks_queue: assert property (@(posedge clock) disable iff (reset)
      q_valid && q_ready && (q_entry.command == tie_pkg::CMD_EVAL) |=> !q_ready)
      else $error("back end took a word while evaluating");

   queue_full_stalls_req: assert property (@(posedge clock) disable iff (reset)
      !req_ready && q_valid && q_ready |=> req_ready)
      else $error("queue did not free a slot after pop");

endmodule

// ===== sv/tie_front.sv =====
module tie_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_command,
   input  logic [tie_pkg::ADDR_W-1:0]        req_coef_address,
   input  logic signed [tie_pkg::COEF_W-1:0] req_coef_value,
   input  logic signed [tie_pkg::COORD_W-1:0] req_coord_1,
   input  logic signed [tie_pkg::COORD_W-1:0] req_coord_2,
   input  logic signed [tie_pkg::COORD_W-1:0] req_coord_3,
   input  logic signed [tie_pkg::COORD_W-1:0] req_coord_4,
   output logic                              q_valid,
   input  logic                              q_ready,
   output tie_pkg::entry_type                q_entry
);

   localparam int PTR_W = $clog2(tie_pkg::Q_DEPTH);
   localparam int CNT_W = $clog2(tie_pkg::Q_DEPTH + 1);

   tie_pkg::entry_type buf_ff [tie_pkg::Q_DEPTH];
   tie_pkg::entry_type word_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign req_ready = (cnt_ff != CNT_W'(tie_pkg::Q_DEPTH));
   assign q_valid   = (cnt_ff != '0);
   assign q_entry   = buf_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   // loads carry no coordinates
   always_comb begin
      word_in              = '0;
      word_in.command      = req_command;
      word_in.coef_address = req_coef_address;
      word_in.coef_value   = req_coef_value;
      if (req_command == tie_pkg::CMD_EVAL) begin
         word_in.coord[0] = req_coord_1;
         word_in.coord[1] = req_coord_2;
         word_in.coord[2] = req_coord_3;
         word_in.coord[3] = req_coord_4;
      end
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= word_in;
      end
   end

endmodule

// ===== sv/tie_back.sv =====
module tie_back #(
   parameter int CELLS_PER_DIM = tie_pkg::CELLS_PER_DIM_DEF,
   parameter int NUM_FUNCS     = tie_pkg::NUM_FUNCS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tie_pkg::cfg_type                     cfg,
   input  logic                                 q_valid,
   output logic                                 q_ready,
   input  tie_pkg::entry_type                   q_entry,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [tie_pkg::FIDX_OUT_W-1:0]       rsp_func_index,
   output logic signed [tie_pkg::VALUE_W-1:0]   rsp_value,
   output logic                                 rsp_out_of_range,
   output logic                                 rsp_last
);

   localparam int FB_W   = tie_pkg::ADDR_W - tie_pkg::MONO_W;
   localparam int NM_W   = tie_pkg::MONO_W + 1;
   localparam int SH_W   = tie_pkg::ACC_W - tie_pkg::FRAC_W;
   localparam int PROD_W = tie_pkg::COEF_W + tie_pkg::PW_W + 1;
   localparam logic signed [SH_W-1:0] VMAX = SH_W'(64'sd549755813887);
   localparam logic signed [SH_W-1:0] VMIN = -SH_W'(64'sd549755813888);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DIFF  = 4'd1;
   localparam logic [3:0] S_MUL   = 4'd2;
   localparam logic [3:0] S_CLS   = 4'd3;
   localparam logic [3:0] S_P2    = 4'd4;
   localparam logic [3:0] S_P3    = 4'd5;
   localparam logic [3:0] S_BASE  = 4'd6;
   localparam logic [3:0] S_RUN   = 4'd7;
   localparam logic [3:0] S_DRAIN = 4'd8;
   localparam logic [3:0] S_EMIT  = 4'd9;

   logic [tie_pkg::COEF_W-1:0] mem [tie_pkg::STORE_DEPTH];

   logic [3:0] state_ff, state_in;
   tie_pkg::entry_type ent_ff;
   logic [1:0] axis_ff, axis_in;
   logic signed [tie_pkg::COORD_W:0] d_ff, d_in;
   logic signed [63:0] t_ff, t_in;
   logic signed [64:0] t_full;
   logic [tie_pkg::FRAC_W-1:0] frac_ff, frac_in;
   logic [tie_pkg::PW_W-1:0] pw_ff [tie_pkg::AXES][4];
   logic [tie_pkg::CELL_W-1:0] cell_ff [tie_pkg::AXES];
   logic [tie_pkg::CELL_W-1:0] cell_in;
   logic oor_ff, oor_in;
   logic [tie_pkg::CELLNO_W-1:0] cellno_ff;
   logic [tie_pkg::FUNC_W-1:0] fidx_ff, fidx_in;
   logic [NM_W-1:0] nm_ff, nm_in;
   logic [3:0] v_ff;
   logic [1:0] r1_ff, s1_ff, s2_ff;
   logic [tie_pkg::PW_W-1:0] m1_ff, m2_ff, m3_ff;
   logic [2*tie_pkg::PW_W-1:0] m1_full, m2_full, m3_full, p2_full, p3_full;
   logic signed [tie_pkg::COEF_W-1:0] rd_ff, ca_ff, cb_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [tie_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic signed [SH_W-1:0] vsh;
   logic signed [tie_pkg::VALUE_W-1:0] sat;
   logic [15:0] fsum;
   logic [tie_pkg::ADDR_W-1:0] raddr;
   logic issue, out_free, emit, mem_we;
   logic rsp_valid_ff, rsp_valid_in;
   logic [tie_pkg::FIDX_OUT_W-1:0] rsp_fidx_ff;
   logic signed [tie_pkg::VALUE_W-1:0] rsp_value_ff;
   logic rsp_oor_ff, rsp_last_ff;

   assign q_ready  = (state_ff == S_IDLE);
   assign mem_we   = q_ready && q_valid && (q_entry.command == tie_pkg::CMD_LOAD);
   assign issue    = (state_ff == S_RUN);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = (state_ff == S_EMIT) && out_free;

   assign fsum  = 16'(fidx_ff) + 16'(NUM_FUNCS) * 16'(cellno_ff);
   assign raddr = {fsum[FB_W-1:0], nm_ff[tie_pkg::MONO_W-1:0]};

   assign d_in   = $signed({ent_ff.coord[axis_ff][tie_pkg::COORD_W-1], ent_ff.coord[axis_ff]})
                 - $signed({cfg.origin[axis_ff][tie_pkg::COORD_W-1], cfg.origin[axis_ff]});
   assign t_full = d_ff * $signed({1'b0, cfg.inv_step[axis_ff]});
   assign t_in   = t_full[63:0];

   assign p2_full = pw_ff[axis_ff][1] * {1'b0, frac_ff};
   assign p3_full = pw_ff[axis_ff][2] * {1'b0, frac_ff};
   assign m1_full = pw_ff[0][nm_ff[7:6]] * pw_ff[1][nm_ff[5:4]];
   assign m2_full = m1_ff * pw_ff[2][r1_ff];
   assign m3_full = m2_ff * pw_ff[3][s2_ff];

   assign vsh = acc_ff[tie_pkg::ACC_W-1:tie_pkg::FRAC_W];
   always_comb begin
      if (vsh > VMAX) begin
         sat = VMAX[tie_pkg::VALUE_W-1:0];
      end else if (vsh < VMIN) begin
         sat = VMIN[tie_pkg::VALUE_W-1:0];
      end else begin
         sat = vsh[tie_pkg::VALUE_W-1:0];
      end
   end

   always_comb begin
      if (t_ff[63]) begin
         cell_in = '0;
         frac_in = '0;
         oor_in  = 1'b1;
      end else if (t_ff[62:32] >= 31'(CELLS_PER_DIM)) begin
         cell_in = tie_pkg::CELL_W'(CELLS_PER_DIM - 1);
         frac_in = '1;
         oor_in  = 1'b1;
      end else begin
         cell_in = t_ff[32 +: tie_pkg::CELL_W];
         frac_in = t_ff[31:16];
         oor_in  = oor_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      fidx_in  = fidx_ff;
      nm_in    = nm_ff;
      acc_in   = v_ff[3] ? acc_ff + tie_pkg::ACC_W'(prod_ff) : acc_ff;
      unique case (state_ff)
         S_IDLE: begin
            axis_in = '0;
            if (q_valid && q_entry.command == tie_pkg::CMD_EVAL) begin
               state_in = S_DIFF;
            end
         end
         S_DIFF:  state_in = S_MUL;
         S_MUL:   state_in = S_CLS;
         S_CLS:   state_in = S_P2;
         S_P2:    state_in = S_P3;
         S_P3: begin
            axis_in  = axis_ff + 1'b1;
            state_in = (axis_ff == 2'd3) ? S_BASE : S_DIFF;
         end
         S_BASE: begin
            fidx_in  = '0;
            nm_in    = '0;
            acc_in   = '0;
            state_in = S_RUN;
         end
         S_RUN: begin
            nm_in = nm_ff + 1'b1;
            if (nm_ff == NM_W'(tie_pkg::NMONO - 1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (v_ff == '0) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               if (fidx_ff == tie_pkg::FUNC_W'(NUM_FUNCS - 1)) begin
                  state_in = S_IDLE;
               end else begin
                  fidx_in  = fidx_ff + 1'b1;
                  nm_in    = '0;
                  acc_in   = '0;
                  state_in = S_RUN;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         v_ff         <= {v_ff[2:0], issue};
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff <= axis_in;
      fidx_ff <= fidx_in;
      nm_ff   <= nm_in;
      acc_ff  <= acc_in;
      if (state_ff == S_IDLE) begin
         ent_ff <= q_entry;
         oor_ff <= 1'b0;
      end
      if (state_ff == S_DIFF) begin
         d_ff <= d_in;
      end
      if (state_ff == S_MUL) begin
         t_ff <= t_in;
      end
      if (state_ff == S_CLS) begin
         frac_ff             <= frac_in;
         oor_ff              <= oor_in;
         cell_ff[axis_ff]    <= cell_in;
         pw_ff[axis_ff][0]   <= tie_pkg::PW_W'(65536);
         pw_ff[axis_ff][1]   <= {1'b0, frac_in};
      end
      if (state_ff == S_P2) begin
         pw_ff[axis_ff][2] <= p2_full[32:16];
      end
      if (state_ff == S_P3) begin
         pw_ff[axis_ff][3] <= p3_full[32:16];
      end
      if (state_ff == S_BASE) begin
         cellno_ff <= tie_pkg::CELLNO_W'(
            ((32'(cell_ff[0]) * 32'(CELLS_PER_DIM) + 32'(cell_ff[1])) * 32'(CELLS_PER_DIM)
             + 32'(cell_ff[2])) * 32'(CELLS_PER_DIM) + 32'(cell_ff[3]));
      end
      r1_ff   <= nm_ff[3:2];
      s1_ff   <= nm_ff[1:0];
      s2_ff   <= s1_ff;
      m1_ff   <= m1_full[32:16];
      m2_ff   <= m2_full[32:16];
      m3_ff   <= m3_full[32:16];
      ca_ff   <= rd_ff;
      cb_ff   <= ca_ff;
      prod_ff <= cb_ff * $signed({1'b0, m3_ff});
      if (emit) begin
         rsp_fidx_ff  <= fidx_ff[tie_pkg::FIDX_OUT_W-1:0];
         rsp_value_ff <= sat;
         rsp_oor_ff   <= oor_ff;
         rsp_last_ff  <= (fidx_ff == tie_pkg::FUNC_W'(NUM_FUNCS - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[q_entry.coef_address] <= q_entry.coef_value;
      end
      rd_ff <= $signed(mem[raddr]);
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_func_index   = rsp_fidx_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_out_of_range = rsp_oor_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// ===== tb/tetracubic_interpolation_evaluator_tb.sv =====
module tetracubic_interpolation_evaluator_tb;

   localparam int CELLS = tie_pkg::CELLS_PER_DIM_DEF;
   localparam int FUNCS = tie_pkg::NUM_FUNCS_DEF;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic                                           command;
      logic [tie_pkg::ADDR_W-1:0]                     coef_address;
      logic [tie_pkg::COEF_W-1:0]                     coef_value;
      logic [tie_pkg::AXES-1:0][tie_pkg::COORD_W-1:0] coord;
   } req_word_type;

   typedef struct packed {
      logic [tie_pkg::FIDX_OUT_W-1:0] func_index;
      logic [tie_pkg::VALUE_W-1:0]    value;
      logic                           out_of_range;
      logic                           last;
   } result_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic req_command = tie_pkg::CMD_LOAD;
   logic [tie_pkg::ADDR_W-1:0] req_coef_address = '0;
   logic signed [tie_pkg::COEF_W-1:0] req_coef_value = '0;
   logic signed [tie_pkg::COORD_W-1:0] req_coord_1 = '0, req_coord_2 = '0;
   logic signed [tie_pkg::COORD_W-1:0] req_coord_3 = '0, req_coord_4 = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [tie_pkg::FIDX_OUT_W-1:0] rsp_func_index;
   logic signed [tie_pkg::VALUE_W-1:0] rsp_value;
   logic rsp_out_of_range, rsp_last;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [tie_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [tie_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [tie_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   tetracubic_interpolation_evaluator dut (.*);

   initial forever #5 clock = ~clock;

   // shadow of the block's state
   logic [tie_pkg::COEF_W-1:0]  coef_mem [tie_pkg::STORE_DEPTH];
   logic [tie_pkg::COORD_W-1:0] grid_origin [tie_pkg::AXES];
   logic [tie_pkg::INV_W-1:0]   grid_inv_step [tie_pkg::AXES];

   req_word_type pending_words [$];
   result_type   expected_results [$];
   req_word_type cur_word;
   int        burst_left = 0, gap_left = 0;
   int        failures = 0;
   int        cycles = 0;
   int        stall_pct = 0;

   function automatic void predict_eval(input req_word_type w);
      longint d, t, whole, m, acc, v;
      longint pw [tie_pkg::AXES][4];
      longint mono [tie_pkg::NMONO];
      int cell_idx [tie_pkg::AXES];
      longint frac;
      logic oor;
      int cellno, addr;
      result_type r;
      oor = 0;
      for (int a = 0; a < tie_pkg::AXES; a++) begin
         d = longint'($signed(w.coord[a])) - longint'($signed(grid_origin[a]));
         t = d * longint'({33'b0, grid_inv_step[a]});
         if (t < 0) begin
            cell_idx[a] = 0; frac = 0; oor = 1;
         end else begin
            whole = t >>> 32;
            if (whole >= CELLS) begin
               cell_idx[a] = CELLS - 1; frac = 16'hFFFF; oor = 1;
            end else begin
               cell_idx[a] = int'(whole); frac = (t >>> 16) & 16'hFFFF;
            end
         end
         pw[a][0] = 65536;
         for (int k = 1; k < 4; k++) pw[a][k] = (pw[a][k-1] * frac) >>> 16;
      end
      for (int p = 0; p < 4; p++)
         for (int q = 0; q < 4; q++)
            for (int s3 = 0; s3 < 4; s3++)
               for (int s4 = 0; s4 < 4; s4++) begin
                  m = (pw[0][p] * pw[1][q]) >>> 16;
                  m = (m * pw[2][s3]) >>> 16;
                  m = (m * pw[3][s4]) >>> 16;
                  mono[p*64 + q*16 + s3*4 + s4] = m;
               end
      cellno = ((cell_idx[0]*CELLS + cell_idx[1])*CELLS + cell_idx[2])*CELLS + cell_idx[3];
      for (int f = 0; f < FUNCS; f++) begin
         acc = 0;
         for (int n = 0; n < tie_pkg::NMONO; n++) begin
            addr = ((f + FUNCS*cellno)*tie_pkg::NMONO + n) % tie_pkg::STORE_DEPTH;
            acc += longint'($signed(coef_mem[addr])) * mono[n];
         end
         v = acc >>> 16;
         if (v > 64'sd549755813887) v = 64'sd549755813887;
         if (v < -64'sd549755813888) v = -64'sd549755813888;
         r.func_index = f[tie_pkg::FIDX_OUT_W-1:0];
         r.value = v[tie_pkg::VALUE_W-1:0];
         r.out_of_range = oor;
         r.last = (f == FUNCS - 1);
         expected_results.push_back(r);
      end
   endfunction

   function automatic void accept_word(input req_word_type w);
      if (w.command == tie_pkg::CMD_LOAD) coef_mem[w.coef_address] = w.coef_value;
      else predict_eval(w);
   endfunction

   function automatic req_word_type random_word(input logic cmd);
      req_word_type w;
      w.command = cmd;
      w.coef_address = tie_pkg::ADDR_W'($urandom);
      w.coef_value = $urandom;
      for (int a = 0; a < tie_pkg::AXES; a++) w.coord[a] = $urandom;
      return w;
   endfunction

   function automatic void push_load(input int addr, input logic [31:0] val);
      req_word_type w;
      w = random_word(tie_pkg::CMD_LOAD);
      w.coef_address = tie_pkg::ADDR_W'(addr);
      w.coef_value = val;
      pending_words.push_back(w);
   endfunction

   function automatic void push_eval(input logic [31:0] c1, c2, c3, c4);
      req_word_type w;
      w = random_word(tie_pkg::CMD_EVAL);
      w.coord = {c4, c3, c2, c1};
      pending_words.push_back(w);
   endfunction

   // coordinate aimed inside the grid most of the time
   function automatic logic [31:0] aimed_coord(input int a);
      longint tgt, d;
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         tgt = (longint'($urandom_range(0, CELLS - 1)) << 32) | longint'($urandom);
         d = tgt / longint'({33'b0, grid_inv_step[a]});
         return 32'(longint'($signed(grid_origin[a])) + d);
      end
      if (pick < 8) return grid_origin[a];
      return $urandom;
   endfunction

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= tie_pkg::CSR_ADDR_W'({idx, 2'b00}); csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      if (idx <= tie_pkg::REG_ORIGIN_4) grid_origin[idx[1:0]] = val;
      else grid_inv_step[2'(idx - tie_pkg::REG_INV_STEP_1)] = val[tie_pkg::INV_W-1:0];
   endtask

   task automatic drain;
      while (pending_words.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      req_word_type nxt;
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && req_ready) accept_word(cur_word);
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 0;
            end else if (pending_words.size() != 0) begin
               nxt = pending_words.pop_front();
               cur_word <= nxt;
               req_valid <= 1;
               req_command <= nxt.command;
               req_coef_address <= nxt.coef_address;
               req_coef_value <= nxt.coef_value;
               req_coord_1 <= nxt.coord[0];
               req_coord_2 <= nxt.coord[1];
               req_coord_3 <= nxt.coord[2];
               req_coord_4 <= nxt.coord[3];
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 16);
                  gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // monitor and result stall pattern
   always @(posedge clock) begin
      result_type got, want;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tetracubic_interpolation_evaluator test failed");
         $finish;
      end
      if (cycles % 700 == 0) stall_pct <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(10, 90);
      rsp_ready <= reset ? 1'b0 : ($urandom_range(0, 99) >= stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_func_index, rsp_value, rsp_out_of_range, rsp_last};
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result word %p", $time, got);
            failures++;
         end else begin
            want = expected_results.pop_front();
            if (got.func_index !== want.func_index) begin
               $display("%0t: func_index exp %0d got %0d", $time, want.func_index,
                        got.func_index);
               failures++;
            end
            if (got.value !== want.value) begin
               $display("%0t: value exp %0d got %0d", $time, $signed(want.value),
                        $signed(got.value));
               failures++;
            end
            if (got.out_of_range !== want.out_of_range) begin
               $display("%0t: out_of_range exp %0b got %0b", $time, want.out_of_range,
                        got.out_of_range);
               failures++;
            end
            if (got.last !== want.last) begin
               $display("%0t: last exp %0b got %0b", $time, want.last, got.last);
               failures++;
            end
         end
      end
   end

   initial begin
      logic [31:0] val;
      int sat_pos, sat_neg;
      for (int a = 0; a < tie_pkg::AXES; a++) begin
         grid_origin[a] = '0;
         grid_inv_step[a] = tie_pkg::INV_STEP_RESET;
      end
      repeat (5) @(posedge clock);
      reset <= 0;

      // fill the whole store; functions 0 and 1 of the top cell get saturating coefficients
      sat_pos = (0 + FUNCS*15) * tie_pkg::NMONO;
      sat_neg = (1 + FUNCS*15) * tie_pkg::NMONO;
      for (int i = 0; i < tie_pkg::STORE_DEPTH; i++) begin
         if (i >= sat_pos && i < sat_pos + tie_pkg::NMONO) val = 32'h7FFFFFFF;
         else if (i >= sat_neg && i < sat_neg + tie_pkg::NMONO) val = 32'h80000000;
         else if ($urandom_range(0, 7) == 0)
            val = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
         else val = $urandom;
         push_load(i, val);
      end
      drain;

      // directed words at reset configuration
      push_eval(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      push_eval(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
      push_eval(32'h0, 32'h0, 32'h0, 32'h0);
      push_eval(32'h00010000, 32'h0000FFFF, 32'h0001FFFF, 32'h00020000);
      push_eval(32'h0001FFFF, 32'h0001FFFF, 32'h0001FFFF, 32'h0001FFFF);
      push_eval(32'hFFFFFFFF, 32'h00008000, 32'h00018000, 32'h00000001);
      push_load(0, 32'h80000000);
      push_load(tie_pkg::STORE_DEPTH - 1, 32'h7FFFFFFF);
      push_load(1, 32'h0);
      push_eval(32'h0, 32'h0, 32'h0, 32'h0);
      push_eval(32'h0001FFFF, 32'h0001FFFF, 32'h0001FFFF, 32'h0001FFFF);
      drain;

      for (int ph = 0; ph < 5; ph++) begin
         for (int a = 0; a < tie_pkg::AXES; a++) begin
            case (ph)
               0: begin
                  csr_write(3'(tie_pkg::REG_ORIGIN_1 + a),
                            32'($urandom_range(0, 131072)) - 32'd65536);
                  csr_write(3'(tie_pkg::REG_INV_STEP_1 + a), $urandom_range(16384, 262144));
               end
               1: begin
                  csr_write(3'(tie_pkg::REG_ORIGIN_1 + a), 32'h80000000);
                  csr_write(3'(tie_pkg::REG_INV_STEP_1 + a), 32'd1);
               end
               2: begin
                  csr_write(3'(tie_pkg::REG_ORIGIN_1 + a), 32'h7FFFFFFF);
                  csr_write(3'(tie_pkg::REG_INV_STEP_1 + a), 32'h7FFFFFFF);
               end
               default: begin
                  csr_write(3'(tie_pkg::REG_ORIGIN_1 + a), $urandom);
                  csr_write(3'(tie_pkg::REG_INV_STEP_1 + a), $urandom_range(1, 32'h7FFFFFFF));
               end
            endcase
         end
         for (int n = 0; n < 34; n++) begin
            if ($urandom_range(0, 1)) begin
               push_eval(aimed_coord(0), aimed_coord(1), aimed_coord(2), aimed_coord(3));
            end else begin
               pending_words.push_back(random_word(tie_pkg::CMD_LOAD));
            end
         end
         drain;
      end

      if (failures == 0) $display("tetracubic_interpolation_evaluator test passed");
      else $display("tetracubic_interpolation_evaluator test failed");
      $finish;
   end

endmodule

// ===== tetracubic_interpolation_evaluator.f =====
sv/tie_pkg.sv
sv/tie_front.sv
sv/tie_back.sv
sv/tetracubic_interpolation_evaluator.sv
tb/tetracubic_interpolation_evaluator_tb.sv
